>>> src/hwa_pkg.sv
`timescale 1ns / 1ps

package hwa_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int SPEED_W     = 32;
    localparam int DT_W        = 32;
    // |speed| * dt stays below 2^63
    localparam int AREQ_W      = 63;
    // angle per step stays below 2^47 (Q15.32)
    localparam int ANG_W       = AREQ_W - 16;
    localparam int TDIV_W      = ANG_W + 16;
    localparam int PROG_W      = 17;
    localparam logic [PROG_W-1:0] PROG_ONE = 17'd65536;

    localparam logic [CFG_INDEX_W-1:0] REG_JOB_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIPE_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RISE = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_RR,
        OP_MUL_BB,
        OP_SQRT,
        OP_MUL_LA,
        OP_DIV_ANG,
        OP_DIV_TIME,
        OP_MUL_AX,
        OP_DIV_PROG
    } op_t;

    typedef struct packed {
        op_t  op;
        logic start;
        logic capture;
        logic update;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic go;
        logic spd_zero;
        logic prog_trivial;
        logic mul_done;
        logic div_done;
        logic sqrt_done;
    } status_t;

endpackage

>>> src/helix_wrap_advance.sv
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// input     in         in_valid / in_stall     step_valid .. centerline_speed
// output    out        out_valid / out_stall   step_applied .. done_res
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction at a time. Multiply is a 63-bit shift-add; divide is restoring,
// with max(LENGTH_WIDTH+32, 63) quotient bits.
// Skipped step: progress divide only, and none when progress is trivial.
// Applied step: zero speed or trivial progress each drop a divide. Either kind of step
// may also wait under out_stall.
// rst_n clears the configuration, accumulators and completion flag.
// The result register holds under out_stall; a new transaction is taken meanwhile.
module helix_wrap_advance #(
    parameter int LENGTH_WIDTH = 40,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                step_valid,
    input  logic [hwa_pkg::DT_W-1:0]            time_step,
    input  logic signed [1:0]                   rotation_direction,
    input  logic signed [hwa_pkg::SPEED_W-1:0]  rotation_speed,
    input  logic signed [hwa_pkg::SPEED_W-1:0]  centerline_speed,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                step_applied,
    output logic [LENGTH_WIDTH-1:0]             wrapped_total,
    output logic [hwa_pkg::PROG_W-1:0]          progress_fraction,
    output logic signed [ACC_WIDTH-1:0]         support_angle,
    output logic signed [ACC_WIDTH-1:0]         axial_offset,
    output logic [ACC_WIDTH-1:0]                process_time,
    output logic                                done_res,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hwa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [LENGTH_WIDTH-1:0]             cfg_data
);

    hwa_pkg::cmd_t    cmd;
    hwa_pkg::status_t status;

    assign cfg_ready = 1'b1;

    hwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    hwa_dp #(
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .step_valid         (step_valid),
        .time_step          (time_step),
        .rotation_direction (rotation_direction),
        .rotation_speed     (rotation_speed),
        .centerline_speed   (centerline_speed),
        .step_applied       (step_applied),
        .wrapped_total      (wrapped_total),
        .progress_fraction  (progress_fraction),
        .support_angle      (support_angle),
        .axial_offset       (axial_offset),
        .process_time       (process_time),
        .done_res           (done_res)
    );

endmodule

>>> src/hwa_mul.sv
`timescale 1ns / 1ps

// shift-add multiplier, one multiplier bit per cycle
module hwa_mul #(
    parameter int A_W = 41,
    parameter int B_W = 63
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [A_W-1:0]     a_reg;
    logic [A_W+B_W-1:0] p_reg;
    logic [A_W:0]       sum;

    assign sum = {1'b0, p_reg[A_W+B_W-1:B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(B_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg <= a;
            p_reg <= {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_reg <= {sum, p_reg[B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

>>> src/hwa_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; quotient shifts into the dividend register
module hwa_div #(
    parameter int N_W = 72,
    parameter int D_W = 41
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] n,
    input  logic [D_W-1:0] d,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   n_reg;
    logic [D_W-1:0]   d_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W:0]     shifted;
    logic             ge;

    assign shifted = {rem_reg, n_reg[N_W-1]};
    assign ge      = shifted >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            n_reg   <= n;
            d_reg   <= d;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? D_W'(shifted - {1'b0, d_reg}) : D_W'(shifted);
            n_reg   <= {n_reg[N_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = n_reg;

endmodule

>>> src/hwa_dp.sv
`timescale 1ns / 1ps

module hwa_dp #(
    parameter int LENGTH_WIDTH = 40,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hwa_pkg::cmd_t                       cmd,
    output hwa_pkg::status_t                    status,
    input  logic                                cfg_valid,
    input  logic [hwa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [LENGTH_WIDTH-1:0]             cfg_data,
    input  logic                                step_valid,
    input  logic [hwa_pkg::DT_W-1:0]            time_step,
    input  logic signed [1:0]                   rotation_direction,
    input  logic signed [hwa_pkg::SPEED_W-1:0]  rotation_speed,
    input  logic signed [hwa_pkg::SPEED_W-1:0]  centerline_speed,
    output logic                                step_applied,
    output logic [LENGTH_WIDTH-1:0]             wrapped_total,
    output logic [hwa_pkg::PROG_W-1:0]          progress_fraction,
    output logic signed [ACC_WIDTH-1:0]         support_angle,
    output logic signed [ACC_WIDTH-1:0]         axial_offset,
    output logic [ACC_WIDTH-1:0]                process_time,
    output logic                                done_res
);

    localparam int LW    = LENGTH_WIDTH;
    localparam int AW    = ACC_WIDTH;
    localparam int MA    = LW + 1;
    localparam int MB    = hwa_pkg::AREQ_W;
    localparam int PW    = MA + MB;
    localparam int SW    = 2 * LW + 2;
    localparam int RW    = LW + 4;
    localparam int QW    = LW + 16;
    localparam int DN    = (LW + 32 > hwa_pkg::TDIV_W) ? LW + 32 : hwa_pkg::TDIV_W;
    localparam int DD    = (MA > hwa_pkg::SPEED_W) ? MA : hwa_pkg::SPEED_W;
    localparam int SQ_CW = $clog2(MA);

    // configuration
    logic          job_en_reg;
    logic [LW-1:0] total_reg;
    logic [LW-1:0] radius_reg;
    logic [LW-1:0] rise_reg;

    // accumulated state
    logic          complete_reg;
    logic [LW-1:0] wrapped_reg;
    logic [AW-1:0] angle_reg;
    logic [AW-1:0] axial_reg;
    logic [AW-1:0] time_reg;
    logic          applied_reg;

    // per-transaction work registers
    logic                         dir_neg_reg;
    logic [hwa_pkg::SPEED_W-1:0]  spd_mag_reg;
    logic [MB-1:0]                areq_reg;
    logic [SW-1:0]                sq_reg;
    logic [MA-1:0]                lpr_reg;
    logic [LW-1:0]                actual_reg;
    logic [hwa_pkg::ANG_W-1:0]    ang_reg;
    logic [AW-1:0]                tdelta_reg;
    logic [AW-1:0]                axmag_reg;
    logic [hwa_pkg::PROG_W-1:0]   prog_reg;

    // square root unit, two radicand bits per cycle
    logic             sq_busy_reg;
    logic             sq_done_reg;
    logic [SQ_CW-1:0] sq_cnt_reg;
    logic [SW-1:0]    sq_rad_reg;
    logic [RW-1:0]    sq_rem_reg;
    logic [MA-1:0]    sq_root_reg;
    logic [RW-1:0]    sq_shift;
    logic [RW-1:0]    sq_trial;
    logic             sq_ge;

    logic                         b_neg;
    logic [LW-1:0]                b_mag;
    logic [hwa_pkg::SPEED_W-1:0]  spd_mag_in;
    logic [2*hwa_pkg::SPEED_W-1:0] areq_in;

    logic          mul_start;
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic          mul_done;
    logic [PW-1:0] mul_p;
    logic          div_start;
    logic [DN-1:0] div_n;
    logic [DD-1:0] div_d;
    logic          div_done;
    logic [DN-1:0] div_q;

    logic [LW-1:0]    remaining;
    logic [QW-1:0]    rq;
    logic [LW-1:0]    actual_c;
    logic [PW+AW-1:0] ax_ext;
    logic [LW:0]      wsum;
    logic             reach;

    assign b_neg      = rise_reg[LW-1];
    assign b_mag      = b_neg ? (LW'(0) - rise_reg) : rise_reg;
    assign spd_mag_in = rotation_speed[hwa_pkg::SPEED_W-1]
                        ? (hwa_pkg::SPEED_W'(0) - $unsigned(rotation_speed))
                        : $unsigned(rotation_speed);
    assign areq_in    = spd_mag_in * time_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_en_reg <= 1'b0;
            total_reg  <= '0;
            radius_reg <= '0;
            rise_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hwa_pkg::REG_JOB_ENABLE:  job_en_reg <= cfg_data[0];
                hwa_pkg::REG_PIPE_LENGTH: total_reg  <= cfg_data;
                hwa_pkg::REG_RADIUS:      radius_reg <= cfg_data;
                hwa_pkg::REG_RISE:        rise_reg   <= cfg_data;
                default:                  job_en_reg <= job_en_reg;
            endcase
        end
    end

    // length per radian is zero exactly when radius and rise are both zero
    assign status.go = job_en_reg && step_valid && (time_step != '0) && !complete_reg
                       && !centerline_speed[hwa_pkg::SPEED_W-1] && (centerline_speed != '0)
                       && ((radius_reg != '0) || (rise_reg != '0));
    assign status.spd_zero     = spd_mag_reg == '0;
    assign status.prog_trivial = complete_reg || (total_reg == '0);
    assign status.mul_done     = mul_done;
    assign status.div_done     = div_done;
    assign status.sqrt_done    = sq_done_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        div_d = '0;
        case (cmd.op)
            hwa_pkg::OP_MUL_RR:
            begin
                mul_a = MA'(radius_reg);
                mul_b = MB'(radius_reg);
            end
            hwa_pkg::OP_MUL_BB:
            begin
                mul_a = MA'(b_mag);
                mul_b = MB'(b_mag);
            end
            hwa_pkg::OP_MUL_LA:
            begin
                mul_a = lpr_reg;
                mul_b = areq_reg;
            end
            hwa_pkg::OP_MUL_AX:
            begin
                mul_a = MA'(b_mag);
                mul_b = MB'(ang_reg);
            end
            hwa_pkg::OP_DIV_ANG:
            begin
                div_n = DN'({actual_reg, 32'd0});
                div_d = DD'(lpr_reg);
            end
            hwa_pkg::OP_DIV_TIME:
            begin
                div_n = DN'({ang_reg, 16'd0});
                div_d = DD'(spd_mag_reg);
            end
            hwa_pkg::OP_DIV_PROG:
            begin
                div_n = DN'({wrapped_reg, 16'd0});
                div_d = DD'(total_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_start = cmd.start && ((cmd.op == hwa_pkg::OP_MUL_RR)
                       || (cmd.op == hwa_pkg::OP_MUL_BB) || (cmd.op == hwa_pkg::OP_MUL_LA)
                       || (cmd.op == hwa_pkg::OP_MUL_AX));
    assign div_start = cmd.start && ((cmd.op == hwa_pkg::OP_DIV_ANG)
                       || (cmd.op == hwa_pkg::OP_DIV_TIME) || (cmd.op == hwa_pkg::OP_DIV_PROG));

    hwa_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    hwa_div #(
        .N_W (DN),
        .D_W (DD)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .n        (div_n),
        .d        (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sq_shift = {sq_rem_reg[RW-3:0], sq_rad_reg[SW-1:SW-2]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};
    assign sq_ge    = sq_shift >= sq_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            if (cmd.start && (cmd.op == hwa_pkg::OP_SQRT) && !sq_busy_reg)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == SQ_CW'(MA - 1))
                begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && (cmd.op == hwa_pkg::OP_SQRT) && !sq_busy_reg)
        begin
            sq_rad_reg  <= sq_reg;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_rad_reg  <= {sq_rad_reg[SW-3:0], 2'b00};
            sq_rem_reg  <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
            sq_root_reg <= {sq_root_reg[MA-2:0], sq_ge};
        end
    end

    // requested advance is product >> 48, clipped to what is left of the pipe
    assign remaining = (total_reg > wrapped_reg) ? (total_reg - wrapped_reg) : '0;
    assign rq        = mul_p[48 +: QW];
    assign actual_c  = (rq > QW'(remaining)) ? remaining : rq[LW-1:0];
    assign ax_ext    = {{AW{1'b0}}, mul_p};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dir_neg_reg <= rotation_direction[1];
            spd_mag_reg <= spd_mag_in;
            areq_reg    <= (rotation_direction == 2'sd0) ? '0 : MB'(areq_in);
            tdelta_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                hwa_pkg::OP_MUL_RR:
                    if (mul_done) sq_reg <= SW'(mul_p);
                hwa_pkg::OP_MUL_BB:
                    if (mul_done) sq_reg <= sq_reg + SW'(mul_p);
                hwa_pkg::OP_SQRT:
                    if (sq_done_reg) lpr_reg <= sq_root_reg;
                hwa_pkg::OP_MUL_LA:
                    if (mul_done) actual_reg <= actual_c;
                hwa_pkg::OP_DIV_ANG:
                    if (div_done) ang_reg <= div_q[hwa_pkg::ANG_W-1:0];
                hwa_pkg::OP_DIV_TIME:
                    if (div_done) tdelta_reg <= AW'(div_q);
                hwa_pkg::OP_MUL_AX:
                    if (mul_done) axmag_reg <= ax_ext[32 +: AW];
                hwa_pkg::OP_DIV_PROG:
                    if (div_done)
                        prog_reg <= (div_q > DN'(hwa_pkg::PROG_ONE))
                                    ? hwa_pkg::PROG_ONE : div_q[hwa_pkg::PROG_W-1:0];
                default:
                    lpr_reg <= lpr_reg;
            endcase
        end
    end

    assign wsum  = {1'b0, wrapped_reg} + {1'b0, actual_reg};
    assign reach = wsum >= {1'b0, total_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complete_reg <= 1'b0;
            wrapped_reg  <= '0;
            angle_reg    <= '0;
            axial_reg    <= '0;
            time_reg     <= '0;
            applied_reg  <= 1'b0;
        end
        else if (cmd.capture)
        begin
            applied_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            applied_reg  <= 1'b1;
            wrapped_reg  <= reach ? total_reg : wsum[LW-1:0];
            complete_reg <= complete_reg || reach;
            angle_reg    <= dir_neg_reg ? (angle_reg - AW'(ang_reg))
                                        : (angle_reg + AW'(ang_reg));
            axial_reg    <= (b_neg ^ dir_neg_reg) ? (axial_reg - axmag_reg)
                                                  : (axial_reg + axmag_reg);
            time_reg     <= time_reg + tdelta_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            step_applied      <= applied_reg;
            wrapped_total     <= wrapped_reg;
            progress_fraction <= complete_reg ? hwa_pkg::PROG_ONE
                                 : ((total_reg == '0) ? '0 : prog_reg);
            support_angle     <= $signed(angle_reg);
            axial_offset      <= $signed(axial_reg);
            process_time      <= time_reg;
            done_res          <= complete_reg;
        end
    end

endmodule

>>> src/hwa_ctrl.sv
`timescale 1ns / 1ps

module hwa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  hwa_pkg::status_t status,
    output hwa_pkg::cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_MUL_RR    = 11'b00000000010,
        S_MUL_BB    = 11'b00000000100,
        S_SQRT      = 11'b00000001000,
        S_MUL_LA    = 11'b00000010000,
        S_DIV_ANG   = 11'b00000100000,
        S_DIV_TIME  = 11'b00001000000,
        S_MUL_AX    = 11'b00010000000,
        S_UPDATE    = 11'b00100000000,
        S_DIV_PROG  = 11'b01000000000,
        S_OUT       = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   launched_reg;
    logic   launched_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.op         = hwa_pkg::OP_NONE;
        state_next     = state_reg;
        launched_next  = launched_reg;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.go ? S_MUL_RR : S_DIV_PROG;
                end
            end
            S_MUL_RR:
            begin
                cmd.op        = hwa_pkg::OP_MUL_RR;
                cmd.start     = !launched_reg;
                launched_next = 1'b1;
                if (status.mul_done)
                begin
                    launched_next = 1'b0;
                    state_next    = S_MUL_BB;
                end
            end
            S_MUL_BB:
            begin
                cmd.op        = hwa_pkg::OP_MUL_BB;
                cmd.start     = !launched_reg;
                launched_next = 1'b1;
                if (status.mul_done)
                begin
                    launched_next = 1'b0;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op        = hwa_pkg::OP_SQRT;
                cmd.start     = !launched_reg;
                launched_next = 1'b1;
                if (status.sqrt_done)
                begin
                    launched_next = 1'b0;
                    state_next    = S_MUL_LA;
                end
            end
            S_MUL_LA:
            begin
                cmd.op        = hwa_pkg::OP_MUL_LA;
                cmd.start     = !launched_reg;
                launched_next = 1'b1;
                if (status.mul_done)
                begin
                    launched_next = 1'b0;
                    state_next    = S_DIV_ANG;
                end
            end
            S_DIV_ANG:
            begin
                cmd.op        = hwa_pkg::OP_DIV_ANG;
                cmd.start     = !launched_reg;
                launched_next = 1'b1;
                if (status.div_done)
                begin
                    launched_next = 1'b0;
                    state_next    = S_DIV_TIME;
                end
            end
            S_DIV_TIME:
            begin
                // zero speed: time delta stays at the zero loaded on capture
                if (status.spd_zero)
                begin
                    state_next = S_MUL_AX;
                end
                else
                begin
                    cmd.op        = hwa_pkg::OP_DIV_TIME;
                    cmd.start     = !launched_reg;
                    launched_next = 1'b1;
                    if (status.div_done)
                    begin
                        launched_next = 1'b0;
                        state_next    = S_MUL_AX;
                    end
                end
            end
            S_MUL_AX:
            begin
                cmd.op        = hwa_pkg::OP_MUL_AX;
                cmd.start     = !launched_reg;
                launched_next = 1'b1;
                if (status.mul_done)
                begin
                    launched_next = 1'b0;
                    state_next    = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_DIV_PROG;
            end
            S_DIV_PROG:
            begin
                if (status.prog_trivial)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op        = hwa_pkg::OP_DIV_PROG;
                    cmd.start     = !launched_reg;
                    launched_next = 1'b1;
                    if (status.div_done)
                    begin
                        launched_next = 1'b0;
                        state_next    = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                launched_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
